// ===== sv/stepper_step_rate_generator_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the stepper step rate generator
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef STEPPER_STEP_RATE_GENERATOR_CORE_ASSERT_SVH
`define STEPPER_STEP_RATE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication
`define SSRG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssrg assertion failed");

// Next-cycle implication
`define SSRG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssrg assertion failed");

`endif

// ===== sv/ssrg_pkg.sv =====
// ---------------------------------------------------------------------------
// ssrg_pkg
// Shared widths, constants and controller/datapath handshake types.
// ---------------------------------------------------------------------------
package ssrg_pkg;

  localparam int TIME_W    = 32;
  localparam int RATE_W    = 15;
  localparam int MAG_W     = 15;  // |rate| up to 16384
  localparam int NUM_W     = 24;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(1000000);

  typedef struct packed {
    logic load;      // capture input word, start divide
    logic div_step;  // one restoring divide step
    logic finish;    // compare, update timestamp, load result
  } cmd_t;

  typedef struct packed {
    logic mag_zero;  // captured rate is zero
    logic out_busy;  // result register full and not being taken
  } sts_t;

endpackage

// ===== sv/ssrg_in_if.sv =====
// ---------------------------------------------------------------------------
// ssrg_in_if
// Input channel: timestamp and signed step rate with valid/ready.
// ---------------------------------------------------------------------------
interface ssrg_in_if import ssrg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        now_time;
  logic signed [RATE_W-1:0] step_rate;

  modport source (output valid, now_time, step_rate, input ready);
  modport sink   (input valid, now_time, step_rate, output ready);
endinterface

// ===== sv/ssrg_out_if.sv =====
// ---------------------------------------------------------------------------
// ssrg_out_if
// Result channel: one step pulse flag per word, valid/ready.
// ---------------------------------------------------------------------------
interface ssrg_out_if ();
  logic valid;
  logic ready;
  logic step_pulse;

  modport source (output valid, step_pulse, input ready);
  modport sink   (input valid, step_pulse, output ready);
endinterface

// ===== sv/ssrg_ctrl.sv =====
// ---------------------------------------------------------------------------
// ssrg_ctrl
// Sequencer: accept a word, run the divide steps, then issue the result.
// ---------------------------------------------------------------------------
module ssrg_ctrl import ssrg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // zero rate: no interval, go straight to the result
        if (sts.mag_zero) begin
          state_nxt = ST_CMP;
        end else begin
          cmd.div_step = 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_nxt = ST_CMP;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_CMP: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`include "stepper_step_rate_generator_core_assert.svh"

  `SSRG_ASSERT_NEXT(a_load_starts_div, cmd.load, state_r == ST_DIV)
  `SSRG_ASSERT_NOW(a_cnt_in_range, state_r == ST_DIV, cnt_r < CNT_W'(DIV_STEPS))
  `SSRG_ASSERT_NEXT(a_finish_frees_input, cmd.finish, in_ready)

endmodule

// ===== sv/ssrg_dp.sv =====
// ---------------------------------------------------------------------------
// ssrg_dp
// Datapath: numerator register, bit-serial restoring divider, timestamp
// compare and the result register.
// ---------------------------------------------------------------------------
module ssrg_dp import ssrg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     cfg_we,
  input  logic [NUM_W-1:0]         cfg_wdata,
  input  logic [TIME_W-1:0]        now_time,
  input  logic signed [RATE_W-1:0] step_rate,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_step_pulse
);

  logic [NUM_W-1:0]  num_r;
  logic [TIME_W-1:0] last_r;
  logic [TIME_W-1:0] now_r;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [NUM_W-1:0]  quot_r, quot_nxt;  // dividend shifts out, quotient in
  logic [MAG_W-1:0]  rem_r, rem_nxt;
  logic [MAG_W:0]    rem_sh;
  logic [TIME_W-1:0] elapsed;
  logic              pulse_c;
  logic              out_valid_r;
  logic              pulse_r;

  // two's complement magnitude; most negative code gives 16384
  assign mag_nxt = step_rate[RATE_W-1] ? MAG_W'(~step_rate + 1'b1) : MAG_W'(step_rate);

  always_comb begin
    rem_sh   = {rem_r, quot_r[NUM_W-1]};
    quot_nxt = {quot_r[NUM_W-2:0], 1'b0};
    rem_nxt  = rem_sh[MAG_W-1:0];
    if (rem_sh >= {1'b0, mag_r}) begin
      rem_nxt     = MAG_W'(rem_sh - {1'b0, mag_r});
      quot_nxt[0] = 1'b1;
    end
  end

  // elapsed time wraps modulo 2^32
  assign elapsed = now_r - last_r;
  assign pulse_c = !sts.mag_zero && (elapsed >= TIME_W'(quot_r));

  assign sts.mag_zero = (mag_r == '0);
  assign sts.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r       <= NUM_RESET;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_r <= cfg_wdata;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (pulse_c) begin
          last_r <= now_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= now_time;
      mag_r  <= mag_nxt;
      quot_r <= num_r;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
    if (cmd.finish) begin
      pulse_r <= pulse_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_pulse = pulse_r;

`include "stepper_step_rate_generator_core_assert.svh"

  `SSRG_ASSERT_NEXT(a_pulse_records_time, cmd.finish && pulse_c, last_r == now_r)
  `SSRG_ASSERT_NEXT(a_zero_rate_no_pulse, cmd.finish && sts.mag_zero, out_valid && !pulse_r)
  `SSRG_ASSERT_NOW(a_no_result_overwrite, cmd.finish, !(out_valid_r && !out_ready))

endmodule

// ===== sv/stepper_step_rate_generator_core.sv =====
// ---------------------------------------------------------------------------
// stepper_step_rate_generator_core
// Step pulse generator: one pulse decision per timestamp/rate word.
//
// in_if  : sink, word = {now_time (32b), step_rate (15b signed)}.
// out_if : source, word = step_pulse, exactly one per input word.
// cfg_we/cfg_wdata : write the 24-bit rate numerator (reset 1000000);
//   write only while no word is in flight.
// An accepted word runs a bit-serial divide, numerator / |rate|, one
// quotient bit a cycle, then a compare step that loads the result; a
// zero rate skips the divide. A new word is accepted only once the
// previous one has been loaded into the result register.
// The result sits in an output register; if the receiver stalls, the
// next word is still taken and divided, and waits in the compare step
// until the register is free. Reset clears the last-step timestamp,
// loads the default numerator and empties the result register.
// ---------------------------------------------------------------------------
module stepper_step_rate_generator_core import ssrg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  ssrg_in_if.sink          in_if,
  ssrg_out_if.source       out_if,
  input  logic             cfg_we,
  input  logic [NUM_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  ssrg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssrg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .now_time       (in_if.now_time),
    .step_rate      (in_if.step_rate),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_step_pulse (out_if.step_pulse)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - step pulse rate generator testbench
// Feeds timestamp/rate words through the input channel under random sender
// gaps and receiver stalls, including one long receiver hold-off. Each
// accepted word is run through a local model of the step interval rule, and
// every result word is checked in order against it. The rate numerator is
// rewritten between phases, extremes included.
// ---------------------------------------------------------------------------
module tb;
  import ssrg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 235;
  localparam int NUM_PHASES     = 7;

  typedef struct {
    logic [TIME_W-1:0]        now;
    logic signed [RATE_W-1:0] rate;
  } poll_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [NUM_W-1:0] cfg_wdata = '0;

  ssrg_in_if  in_if ();
  ssrg_out_if out_if ();

  stepper_step_rate_generator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // model state
  logic [NUM_W-1:0]  numerator = NUM_RESET;
  logic [TIME_W-1:0] last_step_at = '0;

  poll_word_t polls_pending[$];
  logic       pulse_due[$];
  int         errors = 0;
  logic       in_fire = 1'b0;
  bit         idle_on = 1'b1;
  bit         hold_go = 1'b0;
  bit         hold_done = 1'b0;
  int         gap_cnt = 0;
  int         stall_cnt = 0;
  int         hold_cnt = 0;
  int         quiet = 0;
  logic [TIME_W-1:0] clock_us;

  // pulse when the wrapped elapsed time reaches numerator / |rate|
  function automatic logic predict_pulse(input logic [TIME_W-1:0] now,
                                         input logic signed [RATE_W-1:0] rate);
    logic [15:0]       mag;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] elapsed;
    mag = rate[RATE_W-1] ? (16'd32768 - {1'b0, rate}) : {1'b0, rate};
    if (mag == 16'd0) return 1'b0;
    interval = {8'd0, numerator} / {16'd0, mag};
    elapsed  = now - last_step_at;
    if (elapsed >= interval) begin
      last_step_at = now;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_poll(input logic [TIME_W-1:0] now, input int rate);
    poll_word_t w;
    w.now  = now;
    w.rate = RATE_W'(rate);
    polls_pending.push_back(w);
  endtask

  // mostly steady timestamp streams that straddle the interval, some noise
  task automatic queue_random(input int n);
    int run;
    int rate;
    int mag;
    int iv;
    int kind;
    run  = 0;
    rate = 0;
    for (int i = 0; i < n; i++) begin
      if (run == 0) begin
        run  = $urandom_range(1, 40);
        kind = $urandom_range(0, 9);
        if (kind == 0) rate = 0;
        else if (kind == 1) rate = $urandom_range(0, 32767) - 16384;
        else rate = $urandom_range(0, 1) ? $urandom_range(1, 12000)
                                         : -$urandom_range(1, 12000);
      end
      run--;
      if ($urandom_range(0, 15) == 0) begin
        push_poll($urandom, $urandom_range(0, 32767) - 16384);
      end else begin
        mag = (rate < 0) ? -rate : rate;
        iv  = (mag == 0) ? 1000 : int'(numerator) / mag;
        clock_us += $urandom_range(0, iv / 3 + 2);
        push_poll(clock_us, rate);
      end
    end
  endtask

  task automatic queue_directed();
    push_poll(32'd0, 1);
    push_poll(32'd0, 0);
    push_poll(32'hFFFF_FFFF, 0);          // stopped: no pulse however long
    push_poll(32'hFFFF_FFFF, 12000);
    push_poll(32'd40, -12000);            // elapsed across the wrap, short
    push_poll(32'd82, -12000);            // exactly one interval
    push_poll(32'd164, 16383);
    push_poll(32'd200, -16384);
    push_poll(32'd225, -16384);
    push_poll(32'd226, -1);
    push_poll(32'd1000225, 1);
    push_poll(32'd1000226, -1);
    push_poll(32'hFFFF_FFF0, 16383);
    push_poll(32'd20, 16383);
    push_poll(32'd45, 16383);
    push_poll(32'h8000_0000, -2);
    push_poll(32'h7FFF_FFFF, 2);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (polls_pending.size() != 0 || in_if.valid || pulse_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_numerator(input logic [NUM_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    numerator = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender
  always @(negedge clk) begin
    poll_word_t w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (gap_cnt != 0) begin
        gap_cnt     <= gap_cnt - 1;
        in_if.valid <= 1'b0;
      end else if (idle_on && polls_pending.size() != 0 && $urandom_range(0, 7) == 0) begin
        gap_cnt     <= $urandom_range(0, 12);
        in_if.valid <= 1'b0;
      end else if (polls_pending.size() != 0) begin
        w = polls_pending.pop_front();
        in_if.now_time  <= w.now;
        in_if.step_rate <= w.rate;
        in_if.valid     <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done    <= 1'b1;
      hold_cnt     <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt    <= stall_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_cnt    <= $urandom_range(0, 12);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor: predict on each accepted input word, check each result word
  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready)
        pulse_due.push_back(predict_pulse(in_if.now_time, in_if.step_rate));
      if (out_if.valid && out_if.ready) begin
        if (pulse_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual step_pulse=%0b",
                   $time, out_if.step_pulse);
          errors++;
        end else begin
          want = pulse_due.pop_front();
          if (out_if.step_pulse !== want) begin
            $display("%0t: step_pulse mismatch, expected %0b, actual %0b",
                     $time, want, out_if.step_pulse);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [NUM_W-1:0] phase_num[NUM_PHASES];
    in_if.valid     = 1'b0;
    in_if.now_time  = '0;
    in_if.step_rate = '0;
    out_if.ready    = 1'b0;
    phase_num[0] = NUM_RESET;
    phase_num[1] = 24'd1;
    phase_num[2] = 24'hFFFFFF;
    phase_num[3] = 24'd0;
    phase_num[4] = NUM_W'($urandom_range(1, 24'hFFFFFF));
    phase_num[5] = NUM_W'($urandom_range(1, 5000));
    phase_num[6] = NUM_RESET;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_numerator(phase_num[p]);
      idle_on  = (p != 3) && (p != NUM_PHASES - 1);
      clock_us = (p == 1) ? 32'hFFFF_F000 : $urandom;
      if (p == 0) queue_directed();
      // receiver holds off while the sender keeps offering words
      if (p == 2) hold_go = 1'b1;
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (errors == 0 && pulse_due.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
